// ----- sv/pxhex_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the pixel to hex axial mapper.
// Depends on nothing; every other file refers to it by scoped names.
package pxhex_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 16;
   localparam int OUT_W     = 16;
   localparam int SIZE_W    = 10;
   localparam int STAGES    = 8;

   localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(32);

   // sqrt(3)/2 as a 32-bit fraction, rounded to nearest at FRAC_BITS
   localparam longint SQRT3_HALF_Q32 = 64'sd3719550787;
   localparam longint K_VAL =
      (SQRT3_HALF_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
   localparam int K_W = FRAC_BITS;
   localparam logic [K_W-1:0] K = K_W'(K_VAL);

   localparam int DX_W  = IN_W + 1;
   localparam int NUM_W = IN_W + FRAC_BITS;
   localparam int RCP_W = NUM_W + 1;
   localparam int CNT_W = $clog2(RCP_W + 1);
   localparam logic [RCP_W-1:0] RCP_RST =
      RCP_W'((64'd1 << NUM_W) / 64'(SIZE_RST));

   localparam int PX_W  = NUM_W + 1;
   localparam int MAG_W = NUM_W + 2;
   localparam int AX_W  = MAG_W + 1;
   localparam int LO_W  = (MAG_W + 1) / 2;
   localparam int HI_W  = MAG_W - LO_W;

   localparam int D3N_W = LO_W + 2;
   localparam int D3_SH = LO_W + 4;
   localparam int D3M_W = D3_SH - 1;
   localparam logic [D3M_W-1:0] D3_MUL = D3M_W'(((64'd1 << D3_SH) + 64'd2) / 64'd3);

   localparam int SUM_W = AX_W + 1;
   localparam int RND_W = SUM_W - FRAC_BITS + 1;
   localparam int ERR_W = FRAC_BITS;
   localparam int FIN_W = RND_W + 1;

   typedef struct packed {
      logic signed [IN_W-1:0] screen_x;
      logic signed [IN_W-1:0] screen_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] hex_q;
      logic signed [OUT_W-1:0] hex_r;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [RCP_W-1:0]  recip;
      logic              busy;
   } scale_cfg_type;

endpackage

// ----- sv/pxhex_recip.sv -----
`timescale 1ns / 1ps
// Hex size register and serial reciprocal unit: floor(2^NUM_W / size), one bit a cycle.
// Depends on pxhex_pkg.
module pxhex_recip (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pxhex_pkg::SIZE_W-1:0]    csr_wr_data,
   output pxhex_pkg::scale_cfg_type        cfg
);

   logic [pxhex_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [pxhex_pkg::RCP_W-1:0]  quo_ff, quo_in;
   logic [pxhex_pkg::SIZE_W-1:0] rem_ff, rem_in;
   logic [pxhex_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic [pxhex_pkg::SIZE_W:0]   trial;
   logic [pxhex_pkg::SIZE_W:0]   diff;

   always_comb begin
      size_in = size_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, (cnt_ff == '0)};
      diff    = trial - {1'b0, size_ff};
      if (csr_wr_en) begin
         size_in = (csr_wr_data == '0) ? pxhex_pkg::SIZE_W'(1) : csr_wr_data;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, size_ff}) begin
            rem_in = diff[pxhex_pkg::SIZE_W-1:0];
            quo_in = {quo_ff[pxhex_pkg::RCP_W-2:0], 1'b1};
         end else begin
            rem_in = trial[pxhex_pkg::SIZE_W-1:0];
            quo_in = {quo_ff[pxhex_pkg::RCP_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + pxhex_pkg::CNT_W'(1);
         if (cnt_ff == pxhex_pkg::CNT_W'(pxhex_pkg::RCP_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= pxhex_pkg::SIZE_RST;
         quo_ff  <= pxhex_pkg::RCP_RST;
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         size_ff <= size_in;
         quo_ff  <= quo_in;
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign cfg.size  = size_ff;
   assign cfg.recip = quo_ff;
   assign cfg.busy  = busy_ff;

endmodule

// ----- sv/pxhex_scale.sv -----
`timescale 1ns / 1ps
// Stages 0 to 3: origin offset, division by hex size through the reciprocal, sqrt(3)/2 scale.
// Depends on pxhex_pkg and the reciprocal from pxhex_recip.
module pxhex_scale (
   input  logic                                  clock,
   input  logic [3:0]                            en,
   input  pxhex_pkg::req_type                    req,
   input  pxhex_pkg::scale_cfg_type              cfg,
   output logic signed [pxhex_pkg::PX_W-1:0]     px,
   output logic signed [pxhex_pkg::PX_W-1:0]     v
);

   localparam int PRD_W = pxhex_pkg::NUM_W + pxhex_pkg::RCP_W;
   localparam int BCK_W = pxhex_pkg::NUM_W + pxhex_pkg::SIZE_W;
   localparam int SK_W  = pxhex_pkg::SIZE_W + pxhex_pkg::K_W;
   localparam int VP_W  = pxhex_pkg::PX_W + pxhex_pkg::K_W + 1;

   // stage 0
   logic signed [pxhex_pkg::DX_W-1:0]  dx;
   logic [pxhex_pkg::DX_W-1:0]         dx_mag;
   logic [SK_W-1:0]                    size_k;
   logic signed [pxhex_pkg::NUM_W:0]   dyq;
   logic                               sx0_in, sy0_in;
   logic [pxhex_pkg::NUM_W-1:0]        nx0_in, ny0_in;
   logic                               sx0_ff, sy0_ff;
   logic [pxhex_pkg::NUM_W-1:0]        nx0_ff, ny0_ff;

   always_comb begin
      dx = pxhex_pkg::DX_W'(req.screen_x)
         - $signed(pxhex_pkg::DX_W'(cfg.size[pxhex_pkg::SIZE_W-1:1]));
      dx_mag = dx[pxhex_pkg::DX_W-1] ? pxhex_pkg::DX_W'(-dx) : pxhex_pkg::DX_W'(dx);
      size_k = SK_W'(cfg.size) * SK_W'(pxhex_pkg::K);
      dyq = ((pxhex_pkg::NUM_W + 1)'(req.screen_y) <<< pxhex_pkg::FRAC_BITS)
         - $signed((pxhex_pkg::NUM_W + 1)'(size_k));
      sx0_in = dx[pxhex_pkg::DX_W-1];
      sy0_in = dyq[pxhex_pkg::NUM_W];
      nx0_in = {dx_mag[pxhex_pkg::IN_W-1:0], {pxhex_pkg::FRAC_BITS{1'b0}}};
      ny0_in = dyq[pxhex_pkg::NUM_W] ? pxhex_pkg::NUM_W'(-dyq) : pxhex_pkg::NUM_W'(dyq);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sx0_ff <= sx0_in;
         sy0_ff <= sy0_in;
         nx0_ff <= nx0_in;
         ny0_ff <= ny0_in;
      end
   end

   // stage 1: estimate quotient, low by at most one
   logic [PRD_W-1:0]            prdx, prdy;
   logic                        sx1_ff, sy1_ff;
   logic [pxhex_pkg::NUM_W-1:0] nx1_ff, ny1_ff, q0x_ff, q0y_ff;
   logic [pxhex_pkg::NUM_W-1:0] q0x_in, q0y_in;

   always_comb begin
      prdx   = PRD_W'(nx0_ff) * PRD_W'(cfg.recip);
      prdy   = PRD_W'(ny0_ff) * PRD_W'(cfg.recip);
      q0x_in = prdx[pxhex_pkg::NUM_W +: pxhex_pkg::NUM_W];
      q0y_in = prdy[pxhex_pkg::NUM_W +: pxhex_pkg::NUM_W];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sx1_ff <= sx0_ff;
         sy1_ff <= sy0_ff;
         nx1_ff <= nx0_ff;
         ny1_ff <= ny0_ff;
         q0x_ff <= q0x_in;
         q0y_ff <= q0y_in;
      end
   end

   // stage 2: correct the estimate, restore sign
   logic [BCK_W-1:0]                  bckx, bcky;
   logic [pxhex_pkg::NUM_W-1:0]       remx, remy, qx, qy;
   logic signed [pxhex_pkg::PX_W-1:0] px2_in, py2_in, px2_ff, py2_ff;

   always_comb begin
      bckx = BCK_W'(q0x_ff) * BCK_W'(cfg.size);
      bcky = BCK_W'(q0y_ff) * BCK_W'(cfg.size);
      remx = nx1_ff - bckx[pxhex_pkg::NUM_W-1:0];
      remy = ny1_ff - bcky[pxhex_pkg::NUM_W-1:0];
      qx = q0x_ff + pxhex_pkg::NUM_W'(remx >= pxhex_pkg::NUM_W'(cfg.size));
      qy = q0y_ff + pxhex_pkg::NUM_W'(remy >= pxhex_pkg::NUM_W'(cfg.size));
      px2_in = sx1_ff ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      py2_in = sy1_ff ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         px2_ff <= px2_in;
         py2_ff <= py2_in;
      end
   end

   // stage 3: v = trunc(py * K / 2^F)
   logic signed [VP_W-1:0]            vprod, vbias, vshift;
   logic signed [pxhex_pkg::PX_W-1:0] v3_in, px3_ff, v3_ff;

   always_comb begin
      vprod  = py2_ff * $signed({1'b0, pxhex_pkg::K});
      vbias  = vprod + $signed(VP_W'({pxhex_pkg::FRAC_BITS{vprod[VP_W-1]}}));
      vshift = vbias >>> pxhex_pkg::FRAC_BITS;
      v3_in  = $signed(vshift[pxhex_pkg::PX_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         px3_ff <= px2_ff;
         v3_ff  <= v3_in;
      end
   end

   assign px = px3_ff;
   assign v  = v3_ff;

endmodule

// ----- sv/pxhex_axial.sv -----
`timescale 1ns / 1ps
// Stages 4 and 5: fractional axial q = trunc(2px/3) and r = trunc((2v - px)/3).
// Depends on pxhex_pkg; the divide by three is split into two halves over two stages.
module pxhex_axial (
   input  logic                                  clock,
   input  logic [1:0]                            en,
   input  logic signed [pxhex_pkg::PX_W-1:0]     px,
   input  logic signed [pxhex_pkg::PX_W-1:0]     v,
   output logic signed [pxhex_pkg::AX_W-1:0]     qf,
   output logic signed [pxhex_pkg::AX_W-1:0]     rf
);

   localparam int P3_W = pxhex_pkg::D3N_W + pxhex_pkg::D3M_W;

   function automatic logic [pxhex_pkg::D3N_W-1:0] div3(
      input logic [pxhex_pkg::D3N_W-1:0] n);
      logic [P3_W-1:0] p;
      p = P3_W'(n) * P3_W'(pxhex_pkg::D3_MUL);
      return pxhex_pkg::D3N_W'(p >> pxhex_pkg::D3_SH);
   endfunction

   // stage 4: magnitudes, divide upper half
   logic signed [pxhex_pkg::AX_W-1:0]  nq, nr;
   logic [pxhex_pkg::MAG_W-1:0]        mq, mr;
   logic [pxhex_pkg::HI_W-1:0]         hq, hr;
   logic [pxhex_pkg::D3N_W-1:0]        dq, dr;
   logic [pxhex_pkg::HI_W-1:0]         aq_in, ar_in, bq_w, br_w;
   logic                               sq_ff, sr_ff;
   logic [pxhex_pkg::HI_W-1:0]         aq_ff, ar_ff;
   logic [1:0]                         bq_ff, br_ff;
   logic [pxhex_pkg::LO_W-1:0]         lq_ff, lr_ff;

   always_comb begin
      nq = pxhex_pkg::AX_W'(px) <<< 1;
      nr = (pxhex_pkg::AX_W'(v) <<< 1) - pxhex_pkg::AX_W'(px);
      mq = nq[pxhex_pkg::AX_W-1] ? pxhex_pkg::MAG_W'(-nq) : pxhex_pkg::MAG_W'(nq);
      mr = nr[pxhex_pkg::AX_W-1] ? pxhex_pkg::MAG_W'(-nr) : pxhex_pkg::MAG_W'(nr);
      hq = mq[pxhex_pkg::MAG_W-1:pxhex_pkg::LO_W];
      hr = mr[pxhex_pkg::MAG_W-1:pxhex_pkg::LO_W];
      dq = div3(pxhex_pkg::D3N_W'(hq));
      dr = div3(pxhex_pkg::D3N_W'(hr));
      aq_in = dq[pxhex_pkg::HI_W-1:0];
      ar_in = dr[pxhex_pkg::HI_W-1:0];
      bq_w = hq - pxhex_pkg::HI_W'(aq_in * 2'd3);
      br_w = hr - pxhex_pkg::HI_W'(ar_in * 2'd3);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sq_ff <= nq[pxhex_pkg::AX_W-1];
         sr_ff <= nr[pxhex_pkg::AX_W-1];
         aq_ff <= aq_in;
         ar_ff <= ar_in;
         bq_ff <= bq_w[1:0];
         br_ff <= br_w[1:0];
         lq_ff <= mq[pxhex_pkg::LO_W-1:0];
         lr_ff <= mr[pxhex_pkg::LO_W-1:0];
      end
   end

   // stage 5: divide lower half with the carried remainder, restore sign
   logic [pxhex_pkg::D3N_W-1:0]       cq, cr;
   logic [pxhex_pkg::MAG_W-1:0]       uq, ur;
   logic signed [pxhex_pkg::AX_W-1:0] qf_in, rf_in, qf_ff, rf_ff;

   always_comb begin
      cq = div3({bq_ff, lq_ff});
      cr = div3({br_ff, lr_ff});
      uq = {aq_ff, cq[pxhex_pkg::LO_W-1:0]};
      ur = {ar_ff, cr[pxhex_pkg::LO_W-1:0]};
      qf_in = sq_ff ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
      rf_in = sr_ff ? -$signed({1'b0, ur}) : $signed({1'b0, ur});
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         qf_ff <= qf_in;
         rf_ff <= rf_in;
      end
   end

   assign qf = qf_ff;
   assign rf = rf_ff;

endmodule

// ----- sv/pxhex_round.sv -----
`timescale 1ns / 1ps
// Stages 6 and 7: cube rounding of q, r, s, fix-up of the worst coordinate, saturation.
// Depends on pxhex_pkg; stage 7 is the output register.
module pxhex_round (
   input  logic                                  clock,
   input  logic [1:0]                            en,
   input  logic signed [pxhex_pkg::AX_W-1:0]     qf,
   input  logic signed [pxhex_pkg::AX_W-1:0]     rf,
   output pxhex_pkg::rsp_type                    rsp
);

   typedef struct packed {
      logic signed [pxhex_pkg::RND_W-1:0] rnd;
      logic [pxhex_pkg::ERR_W-1:0]        err;
   } rnd_type;

   localparam logic signed [pxhex_pkg::FIN_W-1:0] SAT_MAX =
      pxhex_pkg::FIN_W'((64'sd1 <<< (pxhex_pkg::OUT_W - 1)) - 64'sd1);
   localparam logic signed [pxhex_pkg::FIN_W-1:0] SAT_MIN =
      pxhex_pkg::FIN_W'(-(64'sd1 <<< (pxhex_pkg::OUT_W - 1)));

   function automatic rnd_type round_one(input logic signed [pxhex_pkg::SUM_W-1:0] a);
      logic [pxhex_pkg::SUM_W-1:0]     mag;
      logic [pxhex_pkg::SUM_W-1:0]     up;
      logic [pxhex_pkg::FRAC_BITS-1:0] low;
      logic [pxhex_pkg::RND_W-1:0]     rmag;
      rnd_type                         res;
      mag  = a[pxhex_pkg::SUM_W-1] ? pxhex_pkg::SUM_W'(-a) : pxhex_pkg::SUM_W'(a);
      up   = mag + (pxhex_pkg::SUM_W'(1) << (pxhex_pkg::FRAC_BITS - 1));
      rmag = pxhex_pkg::RND_W'(up >> pxhex_pkg::FRAC_BITS);
      low  = mag[pxhex_pkg::FRAC_BITS-1:0];
      res.err = low[pxhex_pkg::FRAC_BITS-1] ? (~low + pxhex_pkg::FRAC_BITS'(1)) : low;
      res.rnd = a[pxhex_pkg::SUM_W-1] ? -$signed(rmag) : $signed(rmag);
      return res;
   endfunction

   function automatic logic signed [pxhex_pkg::OUT_W-1:0] sat(
      input logic signed [pxhex_pkg::FIN_W-1:0] a);
      logic signed [pxhex_pkg::FIN_W-1:0] c;
      c = a;
      if (a > SAT_MAX) begin
         c = SAT_MAX;
      end else if (a < SAT_MIN) begin
         c = SAT_MIN;
      end
      return $signed(c[pxhex_pkg::OUT_W-1:0]);
   endfunction

   // stage 6: round each coordinate, measure its error
   logic signed [pxhex_pkg::SUM_W-1:0] sf;
   rnd_type                            oq_in, or_in, os_in, oq_ff, or_ff, os_ff;

   always_comb begin
      sf    = -pxhex_pkg::SUM_W'(qf) - pxhex_pkg::SUM_W'(rf);
      oq_in = round_one(pxhex_pkg::SUM_W'(qf));
      or_in = round_one(pxhex_pkg::SUM_W'(rf));
      os_in = round_one(sf);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         oq_ff <= oq_in;
         or_ff <= or_in;
         os_ff <= os_in;
      end
   end

   // stage 7: rebuild the coordinate with the largest error, saturate
   logic signed [pxhex_pkg::FIN_W-1:0] fq, fr;
   pxhex_pkg::rsp_type                 rsp_in, rsp_ff;

   always_comb begin
      priority if (oq_ff.err > or_ff.err && oq_ff.err > os_ff.err) begin
         fq = -pxhex_pkg::FIN_W'(or_ff.rnd) - pxhex_pkg::FIN_W'(os_ff.rnd);
         fr = pxhex_pkg::FIN_W'(or_ff.rnd);
      end else if (or_ff.err > os_ff.err) begin
         fq = pxhex_pkg::FIN_W'(oq_ff.rnd);
         fr = -pxhex_pkg::FIN_W'(oq_ff.rnd) - pxhex_pkg::FIN_W'(os_ff.rnd);
      end else begin
         fq = pxhex_pkg::FIN_W'(oq_ff.rnd);
         fr = pxhex_pkg::FIN_W'(or_ff.rnd);
      end
      rsp_in.hex_q = sat(fq);
      rsp_in.hex_r = sat(fr);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ----- sv/pixel_to_hex_axial_top.sv -----
`timescale 1ns / 1ps
// Pixel to flat-top hex axial mapper. Takes one item per clock while req_ready is high
// and returns its hex_q and hex_r through an eight-stage pipeline with a valid bit per
// stage; a stalled output lets earlier stages keep filling empty slots. Division by
// hex_size uses a stored reciprocal; writing csr_wr_data starts a serial reciprocal
// unit that holds req_ready low while it runs. The reset value of 32 needs no such wait.
// Depends on pxhex_pkg, pxhex_recip, pxhex_scale, pxhex_axial and pxhex_round.
module pixel_to_hex_axial_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pxhex_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pxhex_pkg::rsp_type              rsp_data,
   input  logic                            csr_wr_en,
   input  logic [pxhex_pkg::SIZE_W-1:0]    csr_wr_data
);

   pxhex_pkg::scale_cfg_type              cfg;
   logic [pxhex_pkg::STAGES-1:0]          vld_ff, vld_in, rdy;
   logic                                  accept;
   logic signed [pxhex_pkg::PX_W-1:0]     px, v;
   logic signed [pxhex_pkg::AX_W-1:0]     qf, rf;

   always_comb begin
      rdy[pxhex_pkg::STAGES-1] = ~vld_ff[pxhex_pkg::STAGES-1] | rsp_ready;
      for (int i = pxhex_pkg::STAGES - 2; i >= 0; i--) begin
         rdy[i] = ~vld_ff[i] | rdy[i+1];
      end
   end

   assign req_ready = rdy[0] & ~cfg.busy;
   assign accept    = req_valid & req_ready;

   always_comb begin
      vld_in[0] = rdy[0] ? accept : vld_ff[0];
      for (int i = 1; i < pxhex_pkg::STAGES; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[pxhex_pkg::STAGES-1];

   pxhex_recip u_recip (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   pxhex_scale u_scale (
      .clock (clock),
      .en    (rdy[3:0]),
      .req   (req_data),
      .cfg   (cfg),
      .px    (px),
      .v     (v)
   );

   pxhex_axial u_axial (
      .clock (clock),
      .en    (rdy[5:4]),
      .px    (px),
      .v     (v),
      .qf    (qf),
      .rf    (rf)
   );

   pxhex_round u_round (
      .clock (clock),
      .en    (rdy[7:6]),
      .qf    (qf),
      .rf    (rf),
      .rsp   (rsp_data)
   );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pixel_to_hex_axial_top: predicts hex_q/hex_r per pixel item
// and compares them in order against the rsp channel, over a sweep of hex_size values.
// Depends on pxhex_pkg for the item types and the size width.
module testbench;

   localparam int FRAC_W           = 16;
   localparam int HOLD_CYCLES      = 64;
   localparam int RANDOM_PER_PHASE = 120;
   localparam int SETTLE_CYCLES    = 12;
   localparam int MAX_REPORTS      = 40;

   class hex_cell_board;
      logic [pxhex_pkg::SIZE_W-1:0] hex_size;
      pxhex_pkg::rsp_type           cells_due[$];
      int                           errors;

      function new();
         hex_size = pxhex_pkg::SIZE_W'(32);
         errors   = 0;
      endfunction

      function longint round_fix(longint a);
         longint one;
         longint mag;
         one = 64'sd1 <<< FRAC_W;
         mag = ((a < 0 ? -a : a) + (one >>> 1)) / one;
         return (a < 0) ? -mag : mag;
      endfunction

      function logic signed [15:0] clamp16(longint v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return 16'(v);
      endfunction

      function pxhex_pkg::rsp_type predict_cell(pxhex_pkg::req_type p);
         longint one, s, k, x, y, dx, dyq, px, py, v, qf, rf, sf;
         longint q, r, c, eq, er, ec;
         pxhex_pkg::rsp_type pred;
         one = 64'sd1 <<< FRAC_W;
         s = hex_size;
         if (s == 0) s = 1;
         k = (64'sd3719550787 + (64'sd1 <<< (31 - FRAC_W))) >>> (32 - FRAC_W);
         x = p.screen_x;
         y = p.screen_y;
         dx  = x - (s >>> 1);
         dyq = y * one - s * k;
         px  = (dx * one) / s;
         py  = dyq / s;
         v   = (py * k) / one;
         qf  = (2 * px) / 3;
         rf  = (2 * v - px) / 3;
         sf  = -qf - rf;
         q = round_fix(qf);
         r = round_fix(rf);
         c = round_fix(sf);
         eq = q * one - qf;
         er = r * one - rf;
         ec = c * one - sf;
         if (eq < 0) eq = -eq;
         if (er < 0) er = -er;
         if (ec < 0) ec = -ec;
         if (eq > er && eq > ec) begin
            q = -r - c;
         end else if (er > ec) begin
            r = -q - c;
         end
         pred.hex_q = clamp16(q);
         pred.hex_r = clamp16(r);
         return pred;
      endfunction

      function void note_pixel(pxhex_pkg::req_type p);
         cells_due.push_back(predict_cell(p));
      endfunction

      function void check_cell(pxhex_pkg::rsp_type got);
         pxhex_pkg::rsp_type want;
         if (cells_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected item, expected none, got q=%0d r=%0d",
                        $time, got.hex_q, got.hex_r);
            return;
         end
         want = cells_due.pop_front();
         if (got.hex_q !== want.hex_q) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: hex_q expected %0d, got %0d", $time, want.hex_q, got.hex_q);
         end
         if (got.hex_r !== want.hex_r) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: hex_r expected %0d, got %0d", $time, want.hex_r, got.hex_r);
         end
      endfunction

      function int pending();
         return cells_due.size();
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   pxhex_pkg::req_type           req_data;
   logic                         rsp_valid;
   logic                         rsp_ready;
   pxhex_pkg::rsp_type           rsp_data;
   logic                         csr_wr_en;
   logic [pxhex_pkg::SIZE_W-1:0] csr_wr_data;

   hex_cell_board cells = new();
   bit hold_off_req = 1'b0;
   bit rsp_stalls   = 1'b1;
   bit req_gaps     = 1'b1;

   pixel_to_hex_axial_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic pxhex_pkg::req_type make_pixel(int x, int y);
      pxhex_pkg::req_type p;
      p.screen_x = 16'(x);
      p.screen_y = 16'(y);
      return p;
   endfunction

   function automatic pxhex_pkg::req_type random_pixel(int sz);
      int lim;
      if (sz == 0) sz = 1;
      if ($urandom_range(0, 9) < 6)
         return make_pixel($urandom, $urandom);
      lim = 4 * sz + 8;
      return make_pixel(int'($urandom_range(0, 2 * lim)) - lim,
                        int'($urandom_range(0, 2 * lim)) - lim);
   endfunction

   // entered and left at a falling edge
   task automatic send_pixel(input pxhex_pkg::req_type p, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      cells.note_pixel(p);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (cells.pending() != 0) @(negedge clock);
   endtask

   task automatic write_size(input logic [pxhex_pkg::SIZE_W-1:0] sz);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sz;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cells.hex_size = sz;
   endtask

   task automatic send_corners();
      send_pixel(make_pixel(32767, 32767), 0);
      send_pixel(make_pixel(-32768, -32768), 0);
      send_pixel(make_pixel(32767, -32768), 0);
      send_pixel(make_pixel(-32768, 32767), 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         cells.check_cell(rsp_data);
   end

   // result side: random stalls while rsp_stalls is set, plus one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            stall = rsp_stalls ? pick_gap() : 0;
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int sizes[8];
      int directed[15][2];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      directed = '{'{0, 0}, '{16, 28}, '{15, 27}, '{17, 27}, '{-1, -1}, '{1, 1},
                   '{64, 0}, '{-64, 0}, '{48, 55}, '{40, 14}, '{24, 42}, '{-16, -28},
                   '{100, -100}, '{32767, 0}, '{0, -32768}};
      sizes = '{1, 1023, 0, 2, 3, 7, 0, 32};
      sizes[6] = $urandom_range(4, 1022);
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset value of hex_size
      foreach (directed[i])
         send_pixel(make_pixel(directed[i][0], directed[i][1]), 0);
      send_corners();

      foreach (sizes[ph]) begin
         write_size(pxhex_pkg::SIZE_W'(sizes[ph]));
         req_gaps   = (ph % 4 == 0) || (ph % 4 == 2);
         rsp_stalls = (ph % 4 == 0) || (ph % 4 == 3);
         send_corners();
         if (ph == 1) hold_off_req = 1'b1;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (ph == 2 && n == RANDOM_PER_PHASE / 2)
               wait_drained();
            send_pixel(random_pixel(sizes[ph]), req_gaps ? pick_gap() : 0);
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (cells.errors == 0 && cells.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

// ----- pixel_to_hex_axial_top.f -----
sv/pxhex_pkg.sv
sv/pxhex_recip.sv
sv/pxhex_scale.sv
sv/pxhex_axial.sv
sv/pxhex_round.sv
sv/pixel_to_hex_axial_top.sv
test/testbench.sv
